>>> hdl/arp_cache_and_responder_core_macros.svh
// Assertion macros for the checker file arpc_checker.sv.
`ifndef ARP_CACHE_AND_RESPONDER_CORE_MACROS_SVH
`define ARP_CACHE_AND_RESPONDER_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, quiet while rst_n is low.
`define ARPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("arpc check failed");

// Next-cycle implication, clocked on clk, quiet while rst_n is low.
`define ARPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arpc check failed");

`endif

>>> hdl/arpc_pkg.sv
`default_nettype none

package arpc_pkg;

  localparam int TABLE_ENTRIES = 4;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 2'd1;

  localparam logic REQ_RESOLVE = 1'b0;
  localparam logic REQ_PACKET  = 1'b1;

  localparam logic [2:0] ST_HIT   = 3'd0;
  localparam logic [2:0] ST_MISS  = 3'd1;
  localparam logic [2:0] ST_DROP  = 3'd2;
  localparam logic [2:0] ST_LEARN = 3'd3;
  localparam logic [2:0] ST_REPLY = 3'd4;

  localparam logic [10:0] MIN_ARP_LEN = 11'd28;
  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;
  localparam logic [15:0] OP_REQUEST  = 16'h0001;

  localparam logic [1:0] TX_OP_NONE    = 2'd0;
  localparam logic [1:0] TX_OP_REQUEST = 2'd1;
  localparam logic [1:0] TX_OP_REPLY   = 2'd2;

  localparam logic [47:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        req_type;
    logic [31:0] lookup_ip;
    logic [10:0] frame_len;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] src_ip;
    logic [31:0] target_ip;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] resolved_mac;
    logic        tx_valid;
    logic [1:0]  tx_opcode;
    logic [47:0] tx_dest_mac;
    logic [47:0] tx_target_hw;
    logic [31:0] tx_target_ip;
  } out_item_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_entry;
  } tbl_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/arp_cache_and_responder_core.sv
// A dropped packet goes straight from S_IDLE to S_FIN; otherwise the table
// is scanned one entry a cycle through the registered read port in S_SCAN, checking
// entries until the first match, else all TABLE_ENTRIES, before S_FIN registers the result.
// Throughput: one item at a time; start may be taken in the cycle the result is shown.
// Reset clears the table valid bits, own IP and control state; table data is not cleared.
`default_nettype none

module arp_cache_and_responder_core (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  output logic                                busy,
  input  arpc_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  output arpc_pkg::out_item_t                 out_item,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [arpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [arpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

  state_t                        state_r;
  arpc_pkg::in_item_t            item_r;
  logic                          drop_r;
  logic [arpc_pkg::IDX_W-1:0]    idx_r;
  logic                          chk_vld_r;
  logic [arpc_pkg::IDX_W-1:0]    chk_idx_r;
  logic                          hit_r;
  logic [arpc_pkg::IDX_W-1:0]    hit_idx_r;
  logic [47:0]                   hit_mac_r;
  logic                          free_found_r;
  logic [arpc_pkg::IDX_W-1:0]    free_idx_r;
  logic [31:0]                   own_ip_r;
  logic                          out_valid_r;
  arpc_pkg::out_item_t           out_item_r;

  arpc_pkg::tbl_ctrl_t           tbl_ctrl;
  arpc_pkg::entry_t              rd_entry;
  logic                          rd_valid;

  logic                          accept;
  logic                          bad_pkt;
  logic [31:0]                   key;
  logic                          match;
  logic [arpc_pkg::IDX_W-1:0]    slot;
  arpc_pkg::out_item_t           res;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign bad_pkt = (in_item.frame_len < arpc_pkg::MIN_ARP_LEN) ||
                   (in_item.hw_type != arpc_pkg::HW_ETHERNET) ||
                   (in_item.proto_type != arpc_pkg::PROTO_IPV4);

  assign key   = (item_r.req_type == arpc_pkg::REQ_PACKET) ? item_r.src_ip
                                                            : item_r.lookup_ip;
  assign match = chk_vld_r && rd_valid && (rd_entry.ip == key);
  assign slot  = hit_r ? hit_idx_r : (free_found_r ? free_idx_r : '0);

  always_comb begin
    tbl_ctrl.rd_idx       = idx_r;
    tbl_ctrl.wr_en        = (state_r == S_FIN) && (item_r.req_type == arpc_pkg::REQ_PACKET)
                            && !drop_r;
    tbl_ctrl.wr_idx       = slot;
    tbl_ctrl.wr_entry.ip  = item_r.src_ip;
    tbl_ctrl.wr_entry.mac = item_r.sender_mac;
  end

  always_comb begin
    res = '0;
    if (item_r.req_type == arpc_pkg::REQ_RESOLVE) begin
      if (hit_r) begin
        res.status       = arpc_pkg::ST_HIT;
        res.resolved_mac = hit_mac_r;
      end else begin
        res.status       = arpc_pkg::ST_MISS;
        res.tx_valid     = 1'b1;
        res.tx_opcode    = arpc_pkg::TX_OP_REQUEST;
        res.tx_dest_mac  = arpc_pkg::MAC_BROADCAST;
        res.tx_target_hw = arpc_pkg::MAC_BROADCAST;
        res.tx_target_ip = item_r.lookup_ip;
      end
    end else if (drop_r) begin
      res.status = arpc_pkg::ST_DROP;
    end else if ((item_r.opcode == arpc_pkg::OP_REQUEST) && (item_r.target_ip == own_ip_r)) begin
      res.status       = arpc_pkg::ST_REPLY;
      res.tx_valid     = 1'b1;
      res.tx_opcode    = arpc_pkg::TX_OP_REPLY;
      res.tx_dest_mac  = item_r.sender_mac;
      res.tx_target_hw = item_r.sender_mac;
      res.tx_target_ip = item_r.src_ip;
    end else begin
      res.status = arpc_pkg::ST_LEARN;
    end
  end

  // own MAC is accepted on the port but feeds no result field
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r <= '0;
    end else if (cfg_valid && cfg_ready && (cfg_index == arpc_pkg::CFG_OWN_IP)) begin
      own_ip_r <= cfg_data[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
      chk_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            item_r       <= in_item;
            drop_r       <= (in_item.req_type == arpc_pkg::REQ_PACKET) && bad_pkt;
            idx_r        <= '0;
            chk_vld_r    <= 1'b0;
            hit_r        <= 1'b0;
            free_found_r <= 1'b0;
            if ((in_item.req_type == arpc_pkg::REQ_PACKET) && bad_pkt) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          chk_vld_r <= 1'b1;
          chk_idx_r <= idx_r;
          if (idx_r != arpc_pkg::LAST_IDX) begin
            idx_r <= idx_r + 1'b1;
          end
          if (chk_vld_r) begin
            if (match) begin
              hit_r     <= 1'b1;
              hit_idx_r <= chk_idx_r;
              hit_mac_r <= rd_entry.mac;
              state_r   <= S_FIN;
            end else begin
              if (!rd_valid && !free_found_r) begin
                free_found_r <= 1'b1;
                free_idx_r   <= chk_idx_r;
              end
              if (chk_idx_r == arpc_pkg::LAST_IDX) begin
                state_r <= S_FIN;
              end
            end
          end
        end
        S_FIN: begin
          out_item_r  <= res;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  arpc_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (tbl_ctrl),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid)
  );

endmodule

`default_nettype wire

>>> hdl/arpc_table.sv
`default_nettype none

module arpc_table (
  input  wire                      clk,
  input  wire                      rst_n,
  input  arpc_pkg::tbl_ctrl_t      ctrl,
  output arpc_pkg::entry_t         rd_entry,
  output logic                     rd_valid
);

  arpc_pkg::entry_t                           mem [arpc_pkg::TABLE_ENTRIES];
  logic [arpc_pkg::TABLE_ENTRIES-1:0]         valid_r;
  arpc_pkg::entry_t                           rd_entry_r;
  logic                                       rd_valid_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_idx] <= ctrl.wr_entry;
    end
    rd_entry_r <= mem[ctrl.rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctrl.wr_en) begin
        valid_r[ctrl.wr_idx] <= 1'b1;
      end
      rd_valid_r <= valid_r[ctrl.rd_idx];
    end
  end

  assign rd_entry = rd_entry_r;
  assign rd_valid = rd_valid_r;

endmodule

`default_nettype wire

>>> hdl/arpc_checker.sv
`default_nettype none
`include "arp_cache_and_responder_core_macros.svh"

module arpc_checker (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  input  wire                   busy,
  input  wire                   out_valid,
  input  arpc_pkg::out_item_t   out_item
);

  `ARPC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `ARPC_ASSERT_NOW(a_done_result, $past(rst_n) && $fell(busy), out_valid)
  `ARPC_ASSERT_NOW(a_status_range, out_valid, (out_item.status == arpc_pkg::ST_HIT) || (out_item.status == arpc_pkg::ST_MISS) || (out_item.status == arpc_pkg::ST_DROP) || (out_item.status == arpc_pkg::ST_LEARN) || (out_item.status == arpc_pkg::ST_REPLY))
  `ARPC_ASSERT_NOW(a_tx_flag, out_valid, out_item.tx_valid == ((out_item.status == arpc_pkg::ST_MISS) || (out_item.status == arpc_pkg::ST_REPLY)))
  `ARPC_ASSERT_NOW(a_mac_on_hit, out_valid && (out_item.status != arpc_pkg::ST_HIT), out_item.resolved_mac == '0)

endmodule

bind arp_cache_and_responder_core arpc_checker u_arpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire

>>> sim/tb_arp_cache_and_responder_core.sv
`timescale 1ns / 100ps

module tb_arp_cache_and_responder_core;
  import arpc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE = 6;
  localparam int NUM_PHASES = 5;
  localparam int ITEMS_PER_PHASE = 250;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [15:0] OPC_REPLY = 16'h0002;

  class arp_binding_predictor;
    logic [31:0] own_ip = '0;
    logic [47:0] own_mac = '0;
    logic [31:0] bind_ip [TABLE_ENTRIES];
    logic [47:0] bind_mac [TABLE_ENTRIES];
    bit bind_valid [TABLE_ENTRIES];
    out_item_t predicted_results[$];
    int unsigned errors = 0;
    int unsigned status_seen [5];

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_OWN_IP) begin
        own_ip = data[31:0];
      end else if (idx == CFG_OWN_MAC) begin
        own_mac = data;
      end
    endfunction

    function int find_binding(logic [31:0] ip);
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        if (bind_valid[k] && bind_ip[k] == ip) begin
          return k;
        end
      end
      return -1;
    endfunction

    function void note_transfer(in_item_t it);
      out_item_t e;
      int slot;
      e = '0;
      if (it.req_type == REQ_RESOLVE) begin
        slot = find_binding(it.lookup_ip);
        if (slot >= 0) begin
          e.status = ST_HIT;
          e.resolved_mac = bind_mac[slot];
        end else begin
          e.status = ST_MISS;
          e.tx_valid = 1'b1;
          e.tx_opcode = TX_OP_REQUEST;
          e.tx_dest_mac = MAC_BROADCAST;
          e.tx_target_hw = MAC_BROADCAST;
          e.tx_target_ip = it.lookup_ip;
        end
      end else if (it.frame_len < MIN_ARP_LEN || it.hw_type != HW_ETHERNET ||
                   it.proto_type != PROTO_IPV4) begin
        e.status = ST_DROP;
      end else begin
        slot = find_binding(it.src_ip);
        if (slot < 0) begin
          for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (!bind_valid[k]) begin
              slot = k;
              break;
            end
          end
        end
        if (slot < 0) slot = 0;
        bind_ip[slot] = it.src_ip;
        bind_mac[slot] = it.sender_mac;
        bind_valid[slot] = 1'b1;
        if (it.opcode == OP_REQUEST && it.target_ip == own_ip) begin
          e.status = ST_REPLY;
          e.tx_valid = 1'b1;
          e.tx_opcode = TX_OP_REPLY;
          e.tx_dest_mac = it.sender_mac;
          e.tx_target_hw = it.sender_mac;
          e.tx_target_ip = it.src_ip;
        end else begin
          e.status = ST_LEARN;
        end
      end
      predicted_results.push_back(e);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (predicted_results.size() == 0) begin
        $error("result with nothing outstanding: status %0d", got.status);
        errors++;
        return;
      end
      e = predicted_results.pop_front();
      if (e.status <= ST_REPLY) status_seen[e.status]++;
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.resolved_mac !== e.resolved_mac) begin
        $error("resolved_mac: expected %h, got %h", e.resolved_mac, got.resolved_mac);
        errors++;
      end
      if (got.tx_valid !== e.tx_valid) begin
        $error("tx_valid: expected %0d, got %0d", e.tx_valid, got.tx_valid);
        errors++;
      end
      if (got.tx_opcode !== e.tx_opcode) begin
        $error("tx_opcode: expected %0d, got %0d", e.tx_opcode, got.tx_opcode);
        errors++;
      end
      if (got.tx_dest_mac !== e.tx_dest_mac) begin
        $error("tx_dest_mac: expected %h, got %h", e.tx_dest_mac, got.tx_dest_mac);
        errors++;
      end
      if (got.tx_target_hw !== e.tx_target_hw) begin
        $error("tx_target_hw: expected %h, got %h", e.tx_target_hw, got.tx_target_hw);
        errors++;
      end
      if (got.tx_target_ip !== e.tx_target_ip) begin
        $error("tx_target_ip: expected %h, got %h", e.tx_target_ip, got.tx_target_ip);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_valid;
  out_item_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  arp_binding_predictor sb;
  logic [31:0] ip_pool [POOL_SIZE];
  logic [31:0] cur_own_ip;
  int unsigned items_sent = 0;
  int unsigned settings_used = 1;

  arp_cache_and_responder_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_item);
      if (start && !busy) sb.note_transfer(in_item);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic in_item_t resolve_item(logic [31:0] ip);
    in_item_t it;
    it = '0;
    it.req_type = REQ_RESOLVE;
    it.lookup_ip = ip;
    return it;
  endfunction

  function automatic in_item_t packet_item(logic [10:0] len, logic [15:0] hw,
                                           logic [15:0] proto, logic [15:0] op,
                                           logic [47:0] smac, logic [31:0] sip,
                                           logic [31:0] tip);
    in_item_t it;
    it = '0;
    it.req_type = REQ_PACKET;
    it.frame_len = len;
    it.hw_type = hw;
    it.proto_type = proto;
    it.opcode = op;
    it.sender_mac = smac;
    it.src_ip = sip;
    it.target_ip = tip;
    return it;
  endfunction

  // mostly well-formed traffic over a small address pool so the table fills and evicts
  function automatic in_item_t rand_item();
    in_item_t it;
    logic [223:0] raw;
    int unsigned r;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    r = $urandom_range(99, 0);
    if (r < 40) begin
      it.req_type = REQ_RESOLVE;
      if ($urandom_range(99, 0) < 80) begin
        it.lookup_ip = ip_pool[$urandom_range(POOL_SIZE - 1, 0)];
      end
    end else begin
      it.req_type = REQ_PACKET;
      it.frame_len = 11'($urandom_range(2047, 28));
      it.hw_type = HW_ETHERNET;
      it.proto_type = PROTO_IPV4;
      if ($urandom_range(99, 0) < 85) begin
        it.src_ip = ip_pool[$urandom_range(POOL_SIZE - 1, 0)];
      end
      r = $urandom_range(99, 0);
      if (r < 55) begin
        it.opcode = OP_REQUEST;
      end else if (r < 80) begin
        it.opcode = OPC_REPLY;
      end
      r = $urandom_range(99, 0);
      if (r < 60) begin
        it.target_ip = cur_own_ip;
      end else if (r < 80) begin
        it.target_ip = ip_pool[$urandom_range(POOL_SIZE - 1, 0)];
      end
      if ($urandom_range(99, 0) < 20) begin
        case ($urandom_range(3, 0))
          0: begin
            it.frame_len = 11'($urandom_range(27, 0));
          end
          1: begin
            it.hw_type = 16'($urandom);
          end
          2: begin
            it.proto_type = 16'($urandom);
          end
          default: begin
            it.frame_len = 11'($urandom);
            it.hw_type = 16'($urandom);
            it.proto_type = 16'($urandom);
          end
        endcase
      end
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it, int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (sb.predicted_results.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    in_item_t directed[$];
    logic [31:0] ip_set [NUM_PHASES];
    logic [47:0] mac_set [NUM_PHASES];
    int idle_set [NUM_PHASES];
    int gap;
    logic [31:0] ip_a, ip_b, ip_c, ip_d, ip_e;

    sb = new;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur_own_ip = '0;

    ip_a = 32'hC0A8_0001;
    ip_b = 32'hC0A8_0002;
    ip_c = 32'h0A00_0003;
    ip_d = 32'h0A00_0004;
    ip_e = 32'hAC10_0005;
    ip_set = '{32'hFFFF_FFFF, $urandom, 32'h0, $urandom, $urandom};
    mac_set = '{MAC_BROADCAST, rand48(), 48'h0, rand48(), rand48()};
    idle_set = '{0, 72, 37, 0, 72};

    // own IP still at its reset value of zero here
    directed.push_back(resolve_item(32'h0));
    directed.push_back(resolve_item(32'hFFFF_FFFF));
    directed.push_back(packet_item(11'd27, HW_ETHERNET, PROTO_IPV4, OP_REQUEST,
                                   48'h0200_0000_0001, ip_a, 32'h0));
    directed.push_back(packet_item(11'd0, HW_ETHERNET, PROTO_IPV4, OP_REQUEST,
                                   48'h0200_0000_0001, ip_a, 32'h0));
    directed.push_back(packet_item(MIN_ARP_LEN, 16'h0000, PROTO_IPV4, OP_REQUEST,
                                   48'h0200_0000_0001, ip_a, 32'h0));
    directed.push_back(packet_item(MIN_ARP_LEN, HW_ETHERNET, 16'h0806, OP_REQUEST,
                                   48'h0200_0000_0001, ip_a, 32'h0));
    directed.push_back(packet_item(11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                   MAC_BROADCAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(packet_item(MIN_ARP_LEN, HW_ETHERNET, PROTO_IPV4, OP_REQUEST,
                                   48'h0200_0000_0001, ip_a, 32'h0));
    directed.push_back(resolve_item(ip_a));
    directed.push_back(packet_item(11'd60, HW_ETHERNET, PROTO_IPV4, OPC_REPLY,
                                   48'h0200_0000_0002, ip_b, 32'h0));
    directed.push_back(packet_item(11'h7FF, HW_ETHERNET, PROTO_IPV4, OP_REQUEST,
                                   48'h0200_0000_0003, ip_c, ip_e));
    directed.push_back(packet_item(MIN_ARP_LEN, HW_ETHERNET, PROTO_IPV4, 16'hFFFF,
                                   48'h0200_0000_0004, ip_d, 32'h0));
    directed.push_back(packet_item(11'd46, HW_ETHERNET, PROTO_IPV4, OP_REQUEST,
                                   48'hA5A5_5A5A_C3C3, ip_a, 32'h0));
    directed.push_back(resolve_item(ip_a));
    // table full: new sender evicts entry 0
    directed.push_back(packet_item(MIN_ARP_LEN, HW_ETHERNET, PROTO_IPV4, 16'h0000,
                                   48'h0200_0000_0005, ip_e, 32'h1));
    directed.push_back(resolve_item(ip_a));
    directed.push_back(resolve_item(ip_e));
    directed.push_back(resolve_item(ip_d));
    directed.push_back(packet_item(11'h7FF, HW_ETHERNET, PROTO_IPV4, OP_REQUEST,
                                   MAC_BROADCAST, 32'h0, 32'h0));
    directed.push_back(resolve_item(32'h0));
    directed.push_back(packet_item(MIN_ARP_LEN, HW_ETHERNET, PROTO_IPV4, OP_REQUEST,
                                   48'h0, 32'hFFFF_FFFF, 32'h0));
    directed.push_back(resolve_item(32'hFFFF_FFFF));

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[d]) send_item(directed[d], 0);
    drain_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(CFG_OWN_IP, {16'h0, ip_set[ph]});
      write_reg(CFG_OWN_MAC, mac_set[ph]);
      if (ph % 2 == 0) begin
        write_reg(CFG_SPARE_A, rand48());
        write_reg(CFG_SPARE_B, rand48());
      end
      cur_own_ip = ip_set[ph];
      settings_used++;
      foreach (ip_pool[k]) ip_pool[k] = $urandom;
      if (ph == 0) begin
        ip_pool[0] = 32'h0;
        ip_pool[1] = 32'hFFFF_FFFF;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        gap = 0;
        while ($urandom_range(99, 0) < idle_set[ph]) gap++;
        send_item(rand_item(), gap);
        if ($urandom_range(99, 0) < 2) drain_results();
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d transfers over %0d register settings, sender idle 0/37/72%%.",
             items_sent, settings_used);
    $display("Results by status: hit %0d, miss %0d, drop %0d, learn %0d, reply %0d.",
             sb.status_seen[ST_HIT], sb.status_seen[ST_MISS], sb.status_seen[ST_DROP],
             sb.status_seen[ST_LEARN], sb.status_seen[ST_REPLY]);
    if (sb.errors == 0 && sb.predicted_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
